// ===== rtl/snod_pkg.sv =====
// Shared widths, constants, register codes and interface structs of the onset detector.
`default_nettype none
package snod_pkg;

   localparam int DB_W    = 19;
   localparam int COUNT_W = 8;
   localparam int BIN_W   = 7;
   localparam int FRAME_W = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 19;

   localparam int DEF_MAX_BINS   = 128;
   localparam int DEF_MAX_FRAMES = 65536;

   // -1000 dB with 8 fraction bits
   localparam logic signed [DB_W-1:0] PEAK_FLOOR = -19'sd256000;

   localparam logic signed [DB_W-1:0] THRESHOLD_RESET = -19'sd10240;
   localparam logic [COUNT_W-1:0]     OPEN_RESET      = 8'd4;
   localparam logic [COUNT_W-1:0]     CLOSE_RESET     = 8'd2;
   localparam logic [COUNT_W-1:0]     COUNT_MAX       = 8'd255;

   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OPEN      = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CLOSE     = 2'd2;

   localparam logic FUNC_SAMPLE = 1'b0;
   localparam logic FUNC_END    = 1'b1;

   // Frame summary handed from the bin statistics to the note controller
   typedef struct packed {
      logic               frame_end;
      logic [COUNT_W-1:0] loud_count;
      logic [BIN_W-1:0]   peak_bin;
   } frame_sum_type;

   typedef struct packed {
      logic [BIN_W-1:0]   note_bin;
      logic [FRAME_W-1:0] start_frame;
      logic               is_end;
   } result_type;

endpackage
`default_nettype wire

// ===== rtl/spectral_note_onset_detector.sv =====
// Top level of the spectral note onset detector: config registers, stats, notes, output stage.
//
// Usage:
//   Request channel (req_*): one spectrogram bin per request. req_func selects a bin
//   sample or the end of stream; req_last_bin marks the final bin of a frame. A request
//   is taken at a clock edge with req_valid high and req_stall low.
//   Response channel (rsp_*): a note result (rsp_is_end low) when an open note closes
//   at a frame end, or the terminator (rsp_is_end high) carrying the frame count on
//   end of stream. Taken at an edge with rsp_valid high and rsp_stall low.
//   Config channel (csr_*): index 0 volume threshold, 1 open count, 2 close count.
//   csr_ready is always high; write only while the block is idle.
//   Response path: the response a request causes is registered in the response register,
//   or in the skid entry while that register waits. Throughput: one request per cycle
//   while req_stall is low; all per-bin work is combinational before the response register.
//   Stall: a two-entry output stage (response register plus skid) lets one more
//   request in while a response waits; req_stall rises only when the skid is full.
//   Reset: synchronous, active high; clears statistics, note state, frame count and
//   the output stage, and loads the register reset values.
`default_nettype none
module spectral_note_onset_detector #(
   parameter int MAX_BINS   = snod_pkg::DEF_MAX_BINS,
   parameter int MAX_FRAMES = snod_pkg::DEF_MAX_FRAMES
) (
   input  wire                                   clock,
   input  wire                                   reset,
   // request channel
   input  wire                                   req_valid,
   output logic                                  req_stall,
   input  wire                                   req_func,
   input  wire  signed [snod_pkg::DB_W-1:0]      req_db_value,
   input  wire                                   req_last_bin,
   // response channel
   output logic                                  rsp_valid,
   input  wire                                   rsp_stall,
   output logic [snod_pkg::BIN_W-1:0]            rsp_note_bin,
   output logic [snod_pkg::FRAME_W-1:0]          rsp_start_frame,
   output logic                                  rsp_is_end,
   // configuration channel
   input  wire                                   csr_valid,
   output logic                                  csr_ready,
   input  wire  [snod_pkg::CSR_IDX_W-1:0]        csr_index,
   input  wire  [snod_pkg::CSR_DATA_W-1:0]       csr_data
);

   logic signed [snod_pkg::DB_W-1:0] thr_ff, thr_in;
   logic [snod_pkg::COUNT_W-1:0]     open_ff, open_in;
   logic [snod_pkg::COUNT_W-1:0]     close_ff, close_in;

   logic                    accept;
   logic                    end_accept;
   snod_pkg::frame_sum_type summary;
   logic                    res_valid;
   snod_pkg::result_type    result;

   logic                    out_valid_ff, out_valid_in;
   snod_pkg::result_type    out_ff, out_in;
   logic                    skid_valid_ff, skid_valid_in;
   snod_pkg::result_type    skid_ff, skid_in;
   logic                    out_take;

   assign csr_ready  = 1'b1;
   assign req_stall  = skid_valid_ff;
   assign accept     = req_valid && !skid_valid_ff;
   assign end_accept = accept && (req_func == snod_pkg::FUNC_END);

   // Configuration writes
   always_comb begin
      thr_in   = thr_ff;
      open_in  = open_ff;
      close_in = close_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            snod_pkg::CSR_THRESHOLD: thr_in   = csr_data[snod_pkg::DB_W-1:0];
            snod_pkg::CSR_OPEN:      open_in  = csr_data[snod_pkg::COUNT_W-1:0];
            snod_pkg::CSR_CLOSE:     close_in = csr_data[snod_pkg::COUNT_W-1:0];
            default: begin
               // unused index: drop the write
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff   <= snod_pkg::THRESHOLD_RESET;
         open_ff  <= snod_pkg::OPEN_RESET;
         close_ff <= snod_pkg::CLOSE_RESET;
      end else begin
         thr_ff   <= thr_in;
         open_ff  <= open_in;
         close_ff <= close_in;
      end
   end

   snod_frame_stats #(
      .MAX_BINS (MAX_BINS)
   ) u_stats (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .func      (req_func),
      .db_value  (req_db_value),
      .last_bin  (req_last_bin),
      .threshold (thr_ff),
      .summary   (summary)
   );

   snod_note_ctrl #(
      .MAX_FRAMES (MAX_FRAMES)
   ) u_notes (
      .clock       (clock),
      .reset       (reset),
      .end_accept  (end_accept),
      .summary     (summary),
      .open_count  (open_ff),
      .close_count (close_ff),
      .res_valid   (res_valid),
      .result      (result)
   );

   // Output stage: response register backed by one skid entry
   assign out_take = out_valid_ff && !rsp_stall;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (skid_valid_ff) begin
         // no request enters while the skid holds; advance it when the response leaves
         if (out_take) begin
            out_valid_in  = 1'b1;
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (!out_valid_ff || out_take) begin
         out_valid_in = res_valid;
         out_in       = result;
      end else if (res_valid) begin
         skid_valid_in = 1'b1;
         skid_in       = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_note_bin    = out_ff.note_bin;
   assign rsp_start_frame = out_ff.start_frame;
   assign rsp_is_end      = out_ff.is_end;

endmodule
`default_nettype wire

// ===== rtl/snod_frame_stats.sv =====
// Per-frame bin statistics: loud-bin count, running peak and bin index.
`default_nettype none
module snod_frame_stats #(
   parameter int MAX_BINS = snod_pkg::DEF_MAX_BINS
) (
   input  wire                                      clock,
   input  wire                                      reset,
   input  wire                                      accept,
   input  wire                                      func,
   input  wire  signed [snod_pkg::DB_W-1:0]         db_value,
   input  wire                                      last_bin,
   input  wire  signed [snod_pkg::DB_W-1:0]         threshold,
   output snod_pkg::frame_sum_type                  summary
);

   localparam int BIN_CAP_INT = (MAX_BINS - 1 > 127) ? 127 : (MAX_BINS - 1);
   localparam logic [snod_pkg::BIN_W-1:0] BIN_CAP = snod_pkg::BIN_W'(BIN_CAP_INT);

   logic [snod_pkg::BIN_W-1:0]          bin_ff, bin_in;
   logic [snod_pkg::COUNT_W-1:0]        loud_ff, loud_in, loud_nx;
   logic signed [snod_pkg::DB_W-1:0]    peak_ff, peak_in;
   logic [snod_pkg::BIN_W-1:0]          pbin_ff, pbin_in, pbin_nx;
   logic                                louder;

   always_comb begin
      louder  = db_value > peak_ff;
      loud_nx = loud_ff;
      if (db_value > threshold && loud_ff != snod_pkg::COUNT_MAX) begin
         loud_nx = loud_ff + 1'b1;
      end
      pbin_nx = louder ? bin_ff : pbin_ff;

      bin_in  = bin_ff;
      loud_in = loud_ff;
      peak_in = peak_ff;
      pbin_in = pbin_ff;
      if (accept) begin
         if (func == snod_pkg::FUNC_END) begin
            bin_in  = '0;
            loud_in = '0;
            peak_in = snod_pkg::PEAK_FLOOR;
            pbin_in = '0;
         end else if (last_bin) begin
            bin_in  = '0;
            loud_in = '0;
            peak_in = snod_pkg::PEAK_FLOOR;
            pbin_in = pbin_nx;
         end else begin
            bin_in  = (bin_ff < BIN_CAP) ? bin_ff + 1'b1 : bin_ff;
            loud_in = loud_nx;
            peak_in = louder ? db_value : peak_ff;
            pbin_in = pbin_nx;
         end
      end
      summary.frame_end  = accept && (func == snod_pkg::FUNC_SAMPLE) && last_bin;
      summary.loud_count = loud_nx;
      summary.peak_bin   = pbin_nx;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bin_ff  <= '0;
         loud_ff <= '0;
         peak_ff <= snod_pkg::PEAK_FLOOR;
         pbin_ff <= '0;
      end else begin
         bin_ff  <= bin_in;
         loud_ff <= loud_in;
         peak_ff <= peak_in;
         pbin_ff <= pbin_in;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/snod_note_ctrl.sv =====
// Note hysteresis, frame counter and result formation.
`default_nettype none
module snod_note_ctrl #(
   parameter int MAX_FRAMES = snod_pkg::DEF_MAX_FRAMES
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  end_accept,
   input  snod_pkg::frame_sum_type              summary,
   input  wire  [snod_pkg::COUNT_W-1:0]         open_count,
   input  wire  [snod_pkg::COUNT_W-1:0]         close_count,
   output logic                                 res_valid,
   output snod_pkg::result_type                 result
);

   localparam int FRAME_CAP_INT = (MAX_FRAMES - 1 > 65535) ? 65535 : (MAX_FRAMES - 1);
   localparam logic [snod_pkg::FRAME_W-1:0] FRAME_CAP = snod_pkg::FRAME_W'(FRAME_CAP_INT);

   logic [snod_pkg::FRAME_W-1:0] frame_ff, frame_in;
   logic                         open_ff, open_in;
   logic [snod_pkg::FRAME_W-1:0] start_ff, start_in;

   always_comb begin
      frame_in  = frame_ff;
      open_in   = open_ff;
      start_in  = start_ff;
      res_valid = 1'b0;
      result.note_bin    = summary.peak_bin;
      result.start_frame = start_ff;
      result.is_end      = 1'b0;
      if (end_accept) begin
         // terminator carries the frame count, then drop all state
         res_valid          = 1'b1;
         result.note_bin    = '0;
         result.start_frame = frame_ff;
         result.is_end      = 1'b1;
         frame_in = '0;
         open_in  = 1'b0;
         start_in = '0;
      end else if (summary.frame_end) begin
         if (!open_ff) begin
            if (summary.loud_count >= open_count) begin
               open_in  = 1'b1;
               start_in = frame_ff;
            end
         end else if (summary.loud_count < close_count) begin
            res_valid = 1'b1;
            open_in   = 1'b0;
         end
         if (frame_ff < FRAME_CAP) begin
            frame_in = frame_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_ff <= '0;
         open_ff  <= 1'b0;
         start_ff <= '0;
      end else begin
         frame_ff <= frame_in;
         open_ff  <= open_in;
         start_ff <= start_in;
      end
   end

endmodule
`default_nettype wire
